[hw/rtl/fsh_pkg.sv]
`default_nettype none
package fsh_pkg;

   localparam int HASH_W     = 31;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 31;
   localparam int SEG_W      = 7;
   localparam int CNT_OUT_W  = 15;
   localparam int WEIGHT_W   = 9;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_MODULUS  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_BASE     = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_ROW_LEN  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_ROW_CNT  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_SEGMENTS = 3'd4;

   // reset values
   localparam logic [HASH_W-1:0] RST_MODULUS  = 31'd1000000007;
   localparam logic [HASH_W-1:0] RST_BASE     = 31'd261;
   localparam logic [14:0]       RST_ROW_LEN  = 15'd1920;
   localparam logic [11:0]       RST_ROW_CNT  = 12'd1080;
   localparam logic [SEG_W-1:0]  RST_SEGMENTS = 7'd8;

   // byte offset that maps a two's complement byte onto 1..256
   localparam logic [WEIGHT_W-1:0] BYTE_BIAS = 9'd129;

   typedef struct packed {
      logic              start;
      logic [HASH_W-1:0] a;
      logic [HASH_W-1:0] b;
   } mm_req_type;

endpackage
`default_nettype wire

[hw/rtl/fsh_if.sv]
`default_nettype none
interface fsh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_byte;
   modport source (output valid, output pixel_byte, input ready);
   modport sink (input valid, input pixel_byte, output ready);
endinterface

interface fsh_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_duplicate;
   logic        was_compared;
   logic [14:0] match_count;
   logic [14:0] hash_total;
   modport source (output valid, output is_duplicate, output was_compared,
                   output match_count, output hash_total, input ready);
   modport sink (input valid, input is_duplicate, input was_compared,
                 input match_count, input hash_total, output ready);
endinterface

interface fsh_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  addr;
   logic [30:0] data;
   modport source (output valid, output addr, output data, input ready);
   modport sink (input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/frame_segment_hash_dedup_unit.sv]
`default_nettype none
// Channel   Role     Word                                      Handshake
// req_bus   sink     pixel_byte                                valid/ready
// rsp_bus   source   is_duplicate, was_compared, match_count,  valid/ready
//                    hash_total
// csr_bus   sink     addr (register index), data               valid/ready, ready tied high
//
// A hashed byte runs three modular multiplies on the shared shift-add-reduce
// unit (reduce power, weight times power, power times base) plus sequencer
// states. A segment end adds the hash store (read old bank, write new bank),
// as does each empty leading segment. The first hashed byte after reset or a
// register write also waits for the row_length / segments_per_row divide.
// Bytes of a disabled frame only advance the position; bytes of an empty
// frame are dropped. Reset clears all control state;
// the hash RAM is not cleared. A stalled rsp_bus holds the frame result while
// the next frame's bytes are still taken; only the following frame end waits.
module frame_segment_hash_dedup_unit import fsh_pkg::*; #(
   parameter int MAX_HASHES    = 16384,
   parameter int MAX_ROW_BYTES = 16384,
   parameter int MAX_ROWS      = 2048
) (
   input wire logic  clock,
   input wire logic  reset,
   fsh_req_if.sink   req_bus,
   fsh_rsp_if.source rsp_bus,
   fsh_csr_if.sink   csr_bus
);
   localparam int LEN_W  = $clog2(MAX_ROW_BYTES + 1);
   localparam int ROWS_W = $clog2(MAX_ROWS + 1);
   localparam int TOT_W  = $clog2(MAX_HASHES + 1);
   localparam int IDX_W  = $clog2(MAX_HASHES);
   localparam int PROD_W = ROWS_W + SEG_W;
   localparam int END_W  = LEN_W + SEG_W + 1;
   localparam int CMP_W  = TOT_W + 5;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_DIV  = 4'd1;
   localparam logic [3:0] ST_SKIP = 4'd2;
   localparam logic [3:0] ST_RD   = 4'd3;
   localparam logic [3:0] ST_WR   = 4'd4;
   localparam logic [3:0] ST_PR   = 4'd5;
   localparam logic [3:0] ST_T    = 4'd6;
   localparam logic [3:0] ST_PW   = 4'd7;
   localparam logic [3:0] ST_ADV  = 4'd8;
   localparam logic [3:0] ST_FIN  = 4'd9;

   // configuration
   logic [HASH_W-1:0] modulus_ff, modulus_in, base_ff, base_in;
   logic [14:0]       row_length_ff, row_length_in;
   logic [11:0]       row_count_ff, row_count_in;
   logic [SEG_W-1:0]  segs_ff, segs_in;

   // sequencer and frame state
   logic [3:0]          state_ff, state_in;
   logic [WEIGHT_W-1:0] w_ff, w_in;
   logic [LEN_W-1:0]    proc_ff, proc_in, byte_ff, byte_in;
   logic                proc_ok_ff, proc_ok_in;
   logic [ROWS_W-1:0]   row_ff, row_in;
   logic [TOT_W-1:0]    row_base_ff, row_base_in, matches_ff, matches_in;
   logic [SEG_W-1:0]    seg_ff, seg_in;
   logic [HASH_W-1:0]   sum_ff, sum_in, power_ff, power_in, pr_ff, pr_in;
   logic [HASH_W-1:0]   store_val_ff, store_val_in;
   logic                store_zero_ff, store_zero_in;
   logic                bank_ff, bank_in;
   logic [14:0]         stored_ff, stored_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in, rsp_dup_ff, rsp_dup_in;
   logic        rsp_cmp_ff, rsp_cmp_in;
   logic [14:0] rsp_match_ff, rsp_match_in, rsp_total_ff, rsp_total_in;

   // derived
   logic [LEN_W-1:0]  len_eff;
   logic [ROWS_W-1:0] rows_eff;
   logic [PROD_W-1:0] total_full;
   logic [TOT_W-1:0]  total;
   logic              active, compared, seg_lt_last, seg_end, dup;
   logic [SEG_W-1:0]  last;
   logic [HASH_W-1:0] m_eff, one_eff;
   logic [END_W-1:0]  end_val;
   logic [IDX_W-1:0]  idx;
   logic [HASH_W:0]   add_sum;
   logic [LEN_W:0]    byte_next;
   logic [ROWS_W:0]   row_next;
   logic              accept, csr_write;

   // shared units
   mm_req_type        mm_req;
   logic              mm_done, div_start, div_done;
   logic [HASH_W-1:0] mm_result;
   logic [LEN_W-1:0]  div_q;
   logic              ram_we;
   logic [IDX_W:0]    ram_waddr, ram_raddr;
   logic [HASH_W-1:0] ram_rdata;

   fsh_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .req     (mm_req),
      .modulus (m_eff),
      .done    (mm_done),
      .result  (mm_result)
   );

   fsh_div #(.N(LEN_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (len_eff),
      .divisor  (segs_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // two banks; top address bit picks the bank
   fsh_ram #(.WIDTH(HASH_W), .DEPTH(2 * MAX_HASHES)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (store_val_ff),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      len_eff  = (32'(row_length_ff) > 32'(MAX_ROW_BYTES)) ? LEN_W'(MAX_ROW_BYTES)
                                                           : LEN_W'(row_length_ff);
      rows_eff = (32'(row_count_ff) > 32'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS)
                                                     : ROWS_W'(row_count_ff);
      total_full  = PROD_W'(rows_eff) * PROD_W'(segs_ff);
      active      = (segs_ff != '0) && (32'(total_full) <= 32'(MAX_HASHES));
      total       = TOT_W'(total_full);
      compared    = (32'(stored_ff) == 32'(total));
      last        = segs_ff - 1'b1;
      seg_lt_last = seg_ff < last;
      m_eff       = (modulus_ff == '0) ? HASH_W'(1) : modulus_ff;
      one_eff     = (m_eff == HASH_W'(1)) ? '0 : HASH_W'(1);
      end_val     = seg_lt_last ? END_W'(END_W'(seg_ff) + 1'b1) * END_W'(proc_ff)
                                : END_W'(len_eff);
      byte_next   = {1'b0, byte_ff} + 1'b1;
      row_next    = {1'b0, row_ff} + 1'b1;
      seg_end     = END_W'(byte_next) >= end_val;
      idx         = IDX_W'(row_base_ff + TOT_W'(seg_ff));
      add_sum     = {1'b0, sum_ff} + {1'b0, mm_result};
      if (add_sum >= {1'b0, m_eff}) begin
         add_sum = add_sum - {1'b0, m_eff};
      end
      dup = compared && (CMP_W'(matches_ff) * CMP_W'(20) > CMP_W'(total) * CMP_W'(19));
   end

   assign accept    = req_bus.valid && req_bus.ready;
   assign csr_write = csr_bus.valid && csr_bus.ready;

   always_comb begin
      modulus_in    = modulus_ff;
      base_in       = base_ff;
      row_length_in = row_length_ff;
      row_count_in  = row_count_ff;
      segs_in       = segs_ff;
      state_in      = state_ff;
      w_in          = w_ff;
      proc_in       = proc_ff;
      proc_ok_in    = proc_ok_ff;
      byte_in       = byte_ff;
      row_in        = row_ff;
      row_base_in   = row_base_ff;
      matches_in    = matches_ff;
      seg_in        = seg_ff;
      sum_in        = sum_ff;
      power_in      = power_ff;
      pr_in         = pr_ff;
      store_val_in  = store_val_ff;
      store_zero_in = store_zero_ff;
      bank_in       = bank_ff;
      stored_in     = stored_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_dup_in    = rsp_dup_ff;
      rsp_cmp_in    = rsp_cmp_ff;
      rsp_match_in  = rsp_match_ff;
      rsp_total_in  = rsp_total_ff;
      mm_req        = '0;
      div_start     = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = {~bank_ff, idx};
      ram_raddr     = {bank_ff, idx};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // map the signed byte onto 1..256
               w_in = WEIGHT_W'({req_bus.pixel_byte[7], req_bus.pixel_byte}) + BYTE_BIAS;
               if (len_eff == '0 || rows_eff == '0) begin
                  state_in = ST_IDLE;          // drop: empty frame
               end else if (!active) begin
                  state_in = ST_ADV;
               end else if (!proc_ok_ff) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  state_in = ST_SKIP;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               proc_in    = div_q;
               proc_ok_in = 1'b1;
               state_in   = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (seg_lt_last && proc_ff == '0) begin
               // empty leading segment hashes to zero
               store_val_in  = '0;
               store_zero_in = 1'b1;
               state_in      = ST_RD;
            end else begin
               mm_req   = '{start: 1'b1, a: one_eff, b: power_ff};
               state_in = ST_PR;
            end
         end
         ST_RD: begin
            state_in = ST_WR;
         end
         ST_WR: begin
            ram_we = 1'b1;
            if (compared && ram_rdata == store_val_ff) begin
               matches_in = matches_ff + 1'b1;
            end
            if (store_zero_ff) begin
               seg_in   = seg_ff + 1'b1;
               state_in = ST_SKIP;
            end else begin
               sum_in   = '0;
               power_in = base_ff;
               if (seg_lt_last) begin
                  seg_in = seg_ff + 1'b1;
               end
               state_in = ST_ADV;
            end
         end
         ST_PR: begin
            if (mm_done) begin
               pr_in    = mm_result;
               mm_req   = '{start: 1'b1, a: mm_result, b: HASH_W'(w_ff)};
               state_in = ST_T;
            end
         end
         ST_T: begin
            if (mm_done) begin
               sum_in   = HASH_W'(add_sum);
               mm_req   = '{start: 1'b1, a: pr_ff, b: base_ff};
               state_in = ST_PW;
            end
         end
         ST_PW: begin
            if (mm_done) begin
               power_in = mm_result;
               if (seg_end) begin
                  store_val_in  = sum_ff;
                  store_zero_in = 1'b0;
                  state_in      = ST_RD;
               end else begin
                  state_in = ST_ADV;
               end
            end
         end
         ST_ADV: begin
            if (byte_next < (LEN_W + 1)'(len_eff)) begin
               byte_in  = LEN_W'(byte_next);
               state_in = ST_IDLE;
            end else begin
               byte_in     = '0;
               seg_in      = '0;
               sum_in      = '0;
               power_in    = base_ff;
               row_in      = ROWS_W'(row_next);
               row_base_in = row_base_ff + TOT_W'(segs_ff);
               state_in    = (row_next < (ROWS_W + 1)'(rows_eff)) ? ST_IDLE : ST_FIN;
            end
         end
         ST_FIN: begin
            // hold until the previous result is taken
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               if (!active) begin
                  rsp_dup_in   = 1'b0;
                  rsp_cmp_in   = 1'b0;
                  rsp_match_in = '0;
                  rsp_total_in = '0;
               end else begin
                  rsp_dup_in   = dup;
                  rsp_cmp_in   = compared;
                  rsp_match_in = compared ? CNT_OUT_W'(matches_ff) : '0;
                  rsp_total_in = CNT_OUT_W'(total);
                  if (!dup) begin
                     bank_in   = ~bank_ff;
                     stored_in = CNT_OUT_W'(total);
                  end
               end
               byte_in     = '0;
               row_in      = '0;
               row_base_in = '0;
               seg_in      = '0;
               sum_in      = '0;
               power_in    = base_ff;
               matches_in  = '0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register write: restart the frame, keep the stored one
      if (csr_write && csr_bus.addr <= REG_SEGMENTS) begin
         case (csr_bus.addr)
            REG_MODULUS:  modulus_in    = csr_bus.data;
            REG_BASE:     base_in       = csr_bus.data;
            REG_ROW_LEN:  row_length_in = csr_bus.data[14:0];
            REG_ROW_CNT:  row_count_in  = csr_bus.data[11:0];
            REG_SEGMENTS: segs_in       = csr_bus.data[SEG_W-1:0];
            default:      segs_in       = segs_ff;
         endcase
         byte_in     = '0;
         row_in      = '0;
         row_base_in = '0;
         seg_in      = '0;
         sum_in      = '0;
         power_in    = (csr_bus.addr == REG_BASE) ? csr_bus.data : base_ff;
         matches_in  = '0;
         proc_ok_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff    <= RST_MODULUS;
         base_ff       <= RST_BASE;
         row_length_ff <= RST_ROW_LEN;
         row_count_ff  <= RST_ROW_CNT;
         segs_ff       <= RST_SEGMENTS;
         state_ff      <= ST_IDLE;
         proc_ok_ff    <= 1'b0;
         byte_ff       <= '0;
         row_ff        <= '0;
         row_base_ff   <= '0;
         matches_ff    <= '0;
         seg_ff        <= '0;
         sum_ff        <= '0;
         power_ff      <= RST_BASE;
         bank_ff       <= 1'b0;
         stored_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         modulus_ff    <= modulus_in;
         base_ff       <= base_in;
         row_length_ff <= row_length_in;
         row_count_ff  <= row_count_in;
         segs_ff       <= segs_in;
         state_ff      <= state_in;
         proc_ok_ff    <= proc_ok_in;
         byte_ff       <= byte_in;
         row_ff        <= row_in;
         row_base_ff   <= row_base_in;
         matches_ff    <= matches_in;
         seg_ff        <= seg_in;
         sum_ff        <= sum_in;
         power_ff      <= power_in;
         bank_ff       <= bank_in;
         stored_ff     <= stored_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      w_ff          <= w_in;
      proc_ff       <= proc_in;
      pr_ff         <= pr_in;
      store_val_ff  <= store_val_in;
      store_zero_ff <= store_zero_in;
      rsp_dup_ff    <= rsp_dup_in;
      rsp_cmp_ff    <= rsp_cmp_in;
      rsp_match_ff  <= rsp_match_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign csr_bus.ready        = 1'b1;
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.is_duplicate = rsp_dup_ff;
   assign rsp_bus.was_compared = rsp_cmp_ff;
   assign rsp_bus.match_count  = rsp_match_ff;
   assign rsp_bus.hash_total   = rsp_total_ff;
endmodule
`default_nettype wire

[hw/rtl/fsh_ram.sv]
`default_nettype none
module fsh_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 32768
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

[hw/rtl/fsh_div.sv]
`default_nettype none
module fsh_div import fsh_pkg::*; #(
   parameter int N = 15
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [N-1:0]     dividend,
   input  wire logic [SEG_W-1:0] divisor,
   output logic                  done,
   output logic      [N-1:0]     quotient
);
   localparam int CW = $clog2(N + 1);

   logic [N-1:0]     dq_ff, dq_in;
   logic [SEG_W-1:0] rem_ff, rem_in, div_ff, div_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [SEG_W:0]   trial;

   always_comb begin
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, dq_ff[N-1]};
      if (start) begin
         dq_in   = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CW'(N - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract where it fits
         if (trial >= {1'b0, div_ff}) begin
            rem_in = SEG_W'(trial - {1'b0, div_ff});
            dq_in  = {dq_ff[N-2:0], 1'b1};
         end else begin
            rem_in = SEG_W'(trial);
            dq_in  = {dq_ff[N-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff;
endmodule
`default_nettype wire

[hw/rtl/fsh_mulmod.sv]
`default_nettype none
module fsh_mulmod import fsh_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mm_req_type        req,
   input  wire logic [HASH_W-1:0] modulus,
   output logic                   done,
   output logic      [HASH_W-1:0] result
);
   // a must be below modulus; one bit of b per cycle, MSB first
   logic [HASH_W-1:0] a_ff, a_in, b_ff, b_in, acc_ff, acc_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [HASH_W:0]   dbl, sum;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      dbl = {acc_ff, 1'b0};
      if (dbl >= {1'b0, modulus}) begin
         dbl = dbl - {1'b0, modulus};
      end
      sum = dbl + (b_ff[HASH_W-1] ? {1'b0, a_ff} : '0);
      if (sum >= {1'b0, modulus}) begin
         sum = sum - {1'b0, modulus};
      end
      if (req.start) begin
         a_in    = req.a;
         b_in    = req.b;
         acc_in  = '0;
         cnt_in  = 5'(HASH_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = HASH_W'(sum);
         b_in   = {b_ff[HASH_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;
endmodule
`default_nettype wire

[hw/rtl/fsh_checker.sv]
`default_nettype none
module fsh_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        is_duplicate,
   input wire logic        was_compared,
   input wire logic [14:0] match_count,
   input wire logic [14:0] hash_total
);
   // result word stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped before taken");

   a_dup_needs_cmp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && is_duplicate |-> was_compared)
      else $error("duplicate without comparison");

   a_no_cmp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !was_compared |-> match_count == 15'd0)
      else $error("matches reported without comparison");

   a_match_le_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && was_compared |-> match_count <= hash_total)
      else $error("more matches than hashes");

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result right after reset");
endmodule

bind frame_segment_hash_dedup_unit fsh_checker u_fsh_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .is_duplicate (rsp_bus.is_duplicate),
   .was_compared (rsp_bus.was_compared),
   .match_count  (rsp_bus.match_count),
   .hash_total   (rsp_bus.hash_total)
);
`default_nettype wire

[tb/tb_frame_segment_hash_dedup_unit.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_frame_segment_hash_dedup_unit;
   import fsh_pkg::*;

   localparam int LIM_HASHES = 16384;
   localparam int LIM_ROW    = 16384;
   localparam int LIM_ROWS   = 2048;
   // quiet cycles before a register write: divide, three multiplies, stores
   // and up to 126 empty segments may still be in flight
   localparam int SETTLE     = 400;
   localparam int RAND_WORDS = 1550;

   typedef enum logic [1:0] {OP_BYTE, OP_CSR, OP_DRAIN} op_kind_type;

   typedef struct packed {
      op_kind_type           kind;
      logic [CSR_ADDR_W-1:0] addr;
      logic [CSR_DATA_W-1:0] data;
   } op_type;

   typedef struct packed {
      logic                 dup;
      logic                 cmp;
      logic [CNT_OUT_W-1:0] match_cnt;
      logic [CNT_OUT_W-1:0] total;
   } verdict_type;

   logic clock;
   logic reset;

   fsh_req_if req_bus ();
   fsh_rsp_if rsp_bus ();
   fsh_csr_if csr_bus ();

   frame_segment_hash_dedup_unit DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   op_type      op_q[$];
   verdict_type verdict_q[$];
   int       errors = 0;
   int       bytes_taken = 0;
   int       bytes_planned = 0;
   int       quiet = 0;

   // shadow of the block: registers and frame state
   longint unsigned modulus = RST_MODULUS, base = RST_BASE;
   longint unsigned row_len = RST_ROW_LEN, row_cnt = RST_ROW_CNT, segs = RST_SEGMENTS;
   longint unsigned bank = 0, stored = 0, acc = 0, pw = RST_BASE;
   longint unsigned col = 0, row = 0, seg = 0, hits = 0;
   logic [HASH_W-1:0] hash_mem [int];

   function automatic longint unsigned eff_len();
      return (row_len > LIM_ROW) ? LIM_ROW : row_len;
   endfunction

   function automatic longint unsigned eff_rows();
      return (row_cnt > LIM_ROWS) ? LIM_ROWS : row_cnt;
   endfunction

   function automatic longint unsigned frame_hashes();
      return eff_rows() * segs;
   endfunction

   function automatic bit check_on();
      return segs != 0 && frame_hashes() <= LIM_HASHES;
   endfunction

   function automatic void restart();
      acc = 0; pw = base; col = 0; row = 0; seg = 0; hits = 0;
   endfunction

   function automatic logic [HASH_W-1:0] mem_rd(int a);
      return hash_mem.exists(a) ? hash_mem[a] : '0;
   endfunction

   // write the new bank, count a match against the stored bank
   function automatic void save_hash(longint unsigned h);
      longint unsigned idx;
      idx = row * segs + seg;
      if (idx >= LIM_HASHES || idx >= frame_hashes()) return;
      hash_mem[int'((bank ^ 1) * LIM_HASHES + idx)] = h[HASH_W-1:0];
      if (stored == frame_hashes() && mem_rd(int'(bank * LIM_HASHES + idx)) == h[HASH_W-1:0])
         hits++;
   endfunction

   function automatic void write_reg(logic [CSR_ADDR_W-1:0] a, logic [CSR_DATA_W-1:0] d);
      case (a)
         REG_MODULUS:  modulus = d;
         REG_BASE:     base = d;
         REG_ROW_LEN:  row_len = d[14:0];
         REG_ROW_CNT:  row_cnt = d[11:0];
         REG_SEGMENTS: segs = d[SEG_W-1:0];
         default: return;
      endcase
      restart();
   endfunction

   // advance the frame by one byte; queue the verdict on the last byte
   function automatic void hash_byte(logic [7:0] b);
      longint unsigned len, rows, last, proc, w, m, fin, tot;
      verdict_type v;
      len = eff_len();
      rows = eff_rows();
      if (len == 0 || rows == 0) return;
      if (check_on()) begin
         last = segs - 1;
         proc = len / segs;
         w = b;
         w = (w < 128) ? w + 129 : w - 127;
         m = (modulus == 0) ? 1 : modulus;
         while (seg < last && proc == 0) begin
            save_hash(0);
            seg++;
         end
         acc = (acc + (w * pw) % m) % m;
         pw = (pw * base) % m;
         fin = (seg < last) ? (seg + 1) * proc : len;
         if (col + 1 >= fin) begin
            save_hash(acc);
            acc = 0;
            pw = base;
            if (seg < last) seg++;
         end
      end
      col++;
      if (col < len) return;
      col = 0; seg = 0; acc = 0; pw = base;
      row++;
      if (row < rows) return;
      v = '0;
      if (check_on()) begin
         tot = frame_hashes();
         v.cmp = (stored == tot);
         v.dup = v.cmp && (hits * 20 > tot * 19);
         v.match_cnt = v.cmp ? hits[CNT_OUT_W-1:0] : '0;
         v.total = tot[CNT_OUT_W-1:0];
         if (!v.dup) begin
            bank ^= 1;
            stored = tot & 16'h7FFF;
         end
      end
      verdict_q.push_back(v);
      restart();
   endfunction

   // idle percentages by phase: sender-heavy, receiver-heavy, none
   function automatic int send_idle();
      int ph;
      ph = bytes_planned ? bytes_taken * 3 / bytes_planned : 0;
      return (ph == 0) ? 28 : (ph == 1) ? 57 : 0;
   endfunction

   function automatic int recv_idle();
      int ph;
      ph = bytes_planned ? bytes_taken * 3 / bytes_planned : 0;
      return (ph == 0) ? 57 : (ph == 1) ? 28 : 0;
   endfunction

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.pixel_byte = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.addr = '0;
      csr_bus.data = '0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // driver: take handshakes into the shadow, then pick the next word
   always @(posedge clock) begin
      logic       nv_req, nv_csr;
      logic [7:0] nv_byte;
      logic [CSR_ADDR_W-1:0] nv_addr;
      logic [CSR_DATA_W-1:0] nv_data;
      nv_byte = req_bus.pixel_byte;
      nv_addr = csr_bus.addr;
      nv_data = csr_bus.data;
      nv_req = 1'b0;
      nv_csr = 1'b0;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            hash_byte(req_bus.pixel_byte);
            bytes_taken++;
         end
         if (csr_bus.valid && csr_bus.ready) write_reg(csr_bus.addr, csr_bus.data);
         if (req_bus.valid && !req_bus.ready) begin
            nv_req = 1'b1;      // hold the byte until taken
         end else if (csr_bus.valid && !csr_bus.ready) begin
            nv_csr = 1'b1;
         end else if (op_q.size() != 0) begin
            case (op_q[0].kind)
               OP_BYTE: begin
                  if ($urandom_range(99) >= send_idle()) begin
                     nv_req = 1'b1;
                     nv_byte = op_q[0].data[7:0];
                     void'(op_q.pop_front());
                  end
               end
               OP_CSR: begin
                  // write only once the block has gone quiet
                  if (verdict_q.size() == 0 && quiet >= SETTLE) begin
                     nv_csr = 1'b1;
                     nv_addr = op_q[0].addr;
                     nv_data = op_q[0].data;
                     void'(op_q.pop_front());
                  end
               end
               default: begin
                  if (verdict_q.size() == 0) void'(op_q.pop_front());
               end
            endcase
         end
         if (verdict_q.size() == 0 && !nv_req && !nv_csr && !req_bus.valid)
            quiet++;
         else
            quiet = 0;
      end
      req_bus.valid <= nv_req;
      req_bus.pixel_byte <= nv_byte;
      csr_bus.valid <= nv_csr;
      csr_bus.addr <= nv_addr;
      csr_bus.data <= nv_data;
   end

   // monitor: stall at random, compare each verdict with the oldest expected
   always @(posedge clock) begin
      verdict_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.is_duplicate, rsp_bus.was_compared,
                rsp_bus.match_count, rsp_bus.hash_total};
         if (verdict_q.size() == 0) begin
            errors++;
            $display("%0t unexpected word dup=%0b cmp=%0b match_cnt=%0d total=%0d",
                     $realtime, got.dup, got.cmp, got.match_cnt, got.total);
         end else begin
            want = verdict_q.pop_front();
            if (got !== want) begin
               errors++;
               $display("%0t mismatch expected dup=%0b cmp=%0b match_cnt=%0d total=%0d",
                        $realtime, want.dup, want.cmp, want.match_cnt, want.total);
               $display("%0t          actual   dup=%0b cmp=%0b match_cnt=%0d total=%0d",
                        $realtime, got.dup, got.cmp, got.match_cnt, got.total);
            end
         end
      end
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle());
   end

   task automatic put_reg(logic [CSR_ADDR_W-1:0] a, int d);
      op_type o;
      o.kind = OP_CSR; o.addr = a; o.data = CSR_DATA_W'(d);
      op_q.push_back(o);
   endtask

   task automatic put_byte(logic [7:0] b);
      op_type o;
      o.kind = OP_BYTE; o.addr = '0; o.data = {23'd0, b};
      op_q.push_back(o);
      bytes_planned++;
   endtask

   task automatic put_geometry(int len, int rows, int nseg);
      put_reg(REG_ROW_LEN, len);
      put_reg(REG_ROW_CNT, rows);
      put_reg(REG_SEGMENTS, nseg);
   endtask

   task automatic put_noise(int n);
      repeat (n) put_byte(8'($urandom_range(255)));
   endtask

   initial begin
      logic [7:0] pic[$];
      logic [7:0] prev[$];
      op_type drain;
      int len, rows, nseg, nfr, sel, k;
      drain.kind = OP_DRAIN; drain.addr = '0; drain.data = '0;

      // same frame twice is a duplicate; one changed hash of four is not
      put_geometry(4, 2, 2);
      pic = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'h01, 8'hFE, 8'h55, 8'hAA};
      foreach (pic[i]) put_byte(pic[i]);
      foreach (pic[i]) put_byte(pic[i]);
      pic[5] = 8'h33;
      foreach (pic[i]) put_byte(pic[i]);
      // check disabled: all-zero verdict
      put_reg(REG_SEGMENTS, 0);
      put_noise(8);
      // more segments than bytes: leading runs empty
      put_geometry(3, 1, 6);
      put_noise(3);
      put_noise(3);
      // modulus zero and base zero
      put_reg(REG_MODULUS, 0);
      put_reg(REG_BASE, 0);
      put_noise(3);
      put_reg(REG_MODULUS, 2);
      put_reg(REG_BASE, 32'h7FFFFFFF);
      put_noise(3);
      put_reg(REG_MODULUS, 32'h7FFFFFFF);
      put_reg(REG_BASE, 1);
      put_noise(3);
      // empty frame: bytes ignored
      put_reg(REG_ROW_CNT, 0);
      put_noise(3);
      // saturated row count, too many hashes: check off; abort partway
      put_geometry(1, 4095, 9);
      put_noise(700);
      // abort half a frame with a register write, plus an unused index
      put_geometry(4, 2, 2);
      put_noise(5);
      put_reg(REG_MODULUS, int'(RST_MODULUS));
      put_reg(3'd7, 32'h5A5A5A5A);
      put_reg(REG_BASE, int'(RST_BASE));
      put_noise(8);
      op_q.push_back(drain);

      while (bytes_planned < RAND_WORDS) begin
         len = $urandom_range(1, 6);
         rows = $urandom_range(1, 3);
         sel = $urandom_range(9);
         nseg = (sel == 0) ? 0 : (sel == 1) ? len + $urandom_range(1, 3)
                                            : $urandom_range(1, len);
         sel = $urandom_range(9);
         put_reg(REG_MODULUS, (sel == 0) ? $urandom_range(2, 40) :
                              (sel == 1) ? 32'h7FFFFFFF : $urandom_range(2, 31'h7FFFFFFF));
         sel = $urandom_range(9);
         put_reg(REG_BASE, (sel == 0) ? 1 : (sel == 1) ? 32'h7FFFFFFF
                                                      : $urandom_range(1, 31'h7FFFFFFF));
         put_geometry(len, rows, nseg);
         prev.delete();
         nfr = $urandom_range(2, 6);
         repeat (nfr) begin
            sel = $urandom_range(9);
            pic.delete();
            if (prev.size() != 0 && sel < 5) begin
               pic = prev;
               // sometimes disturb one byte of a repeated frame
               if (sel == 4) pic[$urandom_range(pic.size() - 1)] = 8'($urandom_range(255));
            end else begin
               repeat (len * rows) pic.push_back(8'($urandom_range(255)));
            end
            foreach (pic[i]) put_byte(pic[i]);
            prev = pic;
         end
         // leave a partial frame for the next register write to abort
         if ($urandom_range(7) == 0) begin
            k = $urandom_range(len * rows);
            put_noise(k);
         end
         if ($urandom_range(9) == 0) op_q.push_back(drain);
      end

      while (op_q.size() != 0 || req_bus.valid || csr_bus.valid || verdict_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0 && verdict_q.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #20000000;
      $display("FAILURE");
      $finish;
   end

endmodule
`default_nettype wire
